// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Both macros expect signals named clk and rst in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define PEC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication: when ante holds, cons must hold in the same cycle.
`define PEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`endif

// ----- rtl/pec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_pkg
// Types shared by the ear clipping controller, datapath and top level.
// ----------------------------------------------------------------------------
package pec_pkg;

  typedef enum logic [5:0] {
    ST_LOAD, ST_I0, ST_I1, ST_I2, ST_I3, ST_FILL, ST_PASS,
    ST_E0, ST_E1, ST_E2, ST_E3, ST_E4, ST_E5, ST_E6, ST_E7,
    ST_K0, ST_K1, ST_K2, ST_K3, ST_K4, ST_K5, ST_K6, ST_K7,
    ST_EMIT, ST_SH_RD, ST_SH_WR, ST_FIN,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_END
  } state_t;

  typedef enum logic [1:0] {SEL_A, SEL_B, SEL_C, SEL_P} pt_sel_t;

  typedef enum logic [1:0] {G_ABC, G_ABP, G_BCP, G_CAP} geom_mode_t;

  typedef struct packed {
    logic       vtx_we;
    logic       coord_from_idx;
    pt_sel_t    coord_idx_sel;
    logic       cap_pt;
    pt_sel_t    cap_pt_sel;
    logic       cap_idx;
    pt_sel_t    cap_idx_sel;
    logic       list_we;
    logic       list_from_rd;
    geom_mode_t geom_mode;
    logic       acc_load;
    logic       acc_and;
    logic       out_load;
    logic       out_end;
  } cmd_t;

  typedef struct packed {
    logic same_ab;
    logic cr_nonpos;
    logic blocked;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/pec_geom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_geom
// Corner test on points U, V, W: registered products, then sign flags.
// ----------------------------------------------------------------------------
module pec_geom #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] ux,
  input  logic signed [COORD_BITS-1:0] uy,
  input  logic signed [COORD_BITS-1:0] vx,
  input  logic signed [COORD_BITS-1:0] vy,
  input  logic signed [COORD_BITS-1:0] wx,
  input  logic signed [COORD_BITS-1:0] wy,
  output logic                         cr_nonpos,
  output logic                         below
);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] xn, yn, xk, yk;
  logic signed [PW-1:0] p_cr0, p_cr1, p_dt0, p_dt1;
  logic signed [SW-1:0] cr, dt;

  assign xn = DW'(vx) - DW'(wx);
  assign yn = DW'(vy) - DW'(wy);
  assign xk = DW'(vx) - DW'(ux);
  assign yk = DW'(vy) - DW'(uy);

  always_ff @(posedge clk) begin
    p_cr0 <= xk * yn;
    p_cr1 <= xn * yk;
    p_dt0 <= xk * xn;
    p_dt1 <= yk * yn;
  end

  assign cr = SW'(p_cr0) - SW'(p_cr1);
  assign dt = SW'(p_dt0) + SW'(p_dt1);

  assign cr_nonpos = cr[SW-1] || (cr == '0);
  assign below     = cr[SW-1] || ((cr == '0) && !dt[SW-1]);

endmodule

// ----- rtl/pec_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pec_datapath
// Vertex and list memories, corner registers, corner unit, result register.
// ----------------------------------------------------------------------------
module pec_datapath #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pec_pkg::cmd_t                          cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]        vtx_waddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]        coord_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]        list_raddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]        list_waddr,
  input  logic [$clog2(MAX_VERTICES)-1:0]        list_wdata,
  input  logic [$clog2(MAX_VERTICES+1)-1:0]      out_left,
  input  logic signed [COORD_BITS-1:0]           vertex_x,
  input  logic signed [COORD_BITS-1:0]           vertex_y,
  input  logic                                   out_ready,
  output pec_pkg::status_t                       status,
  output logic                                   out_valid,
  output logic                                   item_kind,
  output logic [$clog2(MAX_VERTICES)-1:0]        corner_prev,
  output logic [$clog2(MAX_VERTICES)-1:0]        corner_tip,
  output logic [$clog2(MAX_VERTICES)-1:0]        corner_next,
  output logic [$clog2(MAX_VERTICES+1)-1:0]      leftover_count,
  output logic                                   run_end
);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic signed [COORD_BITS-1:0] x_mem [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] y_mem [MAX_VERTICES];
  logic [IW-1:0]                list_mem [MAX_VERTICES];

  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic [IW-1:0]                list_rd;
  logic [IW-1:0]                caddr;
  logic [IW-1:0]                ia, ib, ic, ip;
  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy, px, py;
  logic signed [COORD_BITS-1:0] ux, uy, vx, vy, wx, wy;
  logic                         cr_nonpos, below, all_below, same_any;

  always_comb begin
    case (cmd.coord_idx_sel)
      pec_pkg::SEL_A: caddr = ia;
      pec_pkg::SEL_B: caddr = ib;
      pec_pkg::SEL_C: caddr = ic;
      default:        caddr = ip;
    endcase
    if (!cmd.coord_from_idx) begin
      caddr = coord_raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vtx_we) begin
      x_mem[vtx_waddr] <= vertex_x;
      y_mem[vtx_waddr] <= vertex_y;
    end
    rd_x <= x_mem[caddr];
    rd_y <= y_mem[caddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.list_we) begin
      list_mem[list_waddr] <= cmd.list_from_rd ? list_rd : list_wdata;
    end
    list_rd <= list_mem[list_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_idx) begin
      case (cmd.cap_idx_sel)
        pec_pkg::SEL_A: ia <= list_rd;
        pec_pkg::SEL_B: ib <= list_rd;
        pec_pkg::SEL_C: ic <= list_rd;
        default:        ip <= list_rd;
      endcase
    end
    if (cmd.cap_pt) begin
      case (cmd.cap_pt_sel)
        pec_pkg::SEL_A: begin ax <= rd_x; ay <= rd_y; end
        pec_pkg::SEL_B: begin bx <= rd_x; by <= rd_y; end
        pec_pkg::SEL_C: begin cx <= rd_x; cy <= rd_y; end
        default:        begin px <= rd_x; py <= rd_y; end
      endcase
    end
    if (cmd.acc_load) begin
      all_below <= below;
    end else if (cmd.acc_and) begin
      all_below <= all_below & below;
    end
  end

  always_comb begin
    case (cmd.geom_mode)
      pec_pkg::G_ABC: begin
        ux = ax; uy = ay; vx = bx; vy = by; wx = cx; wy = cy;
      end
      pec_pkg::G_ABP: begin
        ux = ax; uy = ay; vx = bx; vy = by; wx = px; wy = py;
      end
      pec_pkg::G_BCP: begin
        ux = bx; uy = by; vx = cx; vy = cy; wx = px; wy = py;
      end
      default: begin
        ux = cx; uy = cy; vx = ax; vy = ay; wx = px; wy = py;
      end
    endcase
  end

  pec_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk      (clk),
    .ux       (ux),
    .uy       (uy),
    .vx       (vx),
    .vy       (vy),
    .wx       (wx),
    .wy       (wy),
    .cr_nonpos(cr_nonpos),
    .below    (below)
  );

  assign same_any = ((px == ax) && (py == ay)) || ((px == bx) && (py == by)) ||
                    ((px == cx) && (py == cy));

  assign status.same_ab   = (ax == bx) && (ay == by);
  assign status.cr_nonpos = cr_nonpos;
  assign status.blocked   = all_below && below && !same_any;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      item_kind      <= cmd.out_end;
      corner_prev    <= cmd.out_end ? '0 : ia;
      corner_tip     <= cmd.out_end ? '0 : ib;
      corner_next    <= cmd.out_end ? '0 : ic;
      leftover_count <= cmd.out_end ? out_left : CW'(0);
      run_end        <= cmd.out_end;
    end
  end

endmodule

// ----- rtl/pec_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pec_ctrl
// Sequencer for loading, list setup, clipping passes and result emission.
// ----------------------------------------------------------------------------
module pec_ctrl #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              final_vertex,
  output logic                              in_ready,
  input  pec_pkg::status_t                  status,
  output pec_pkg::cmd_t                     cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]   vtx_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]   coord_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0]   list_raddr,
  output logic [$clog2(MAX_VERTICES)-1:0]   list_waddr,
  output logic [$clog2(MAX_VERTICES)-1:0]   list_wdata,
  output logic [$clog2(MAX_VERTICES+1)-1:0] out_left
);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_VERTICES);
  localparam logic [CW-1:0] One    = CW'(1);

  pec_pkg::state_t state, state_next;

  logic [CW-1:0] load_count, live, pass_start, i, k;
  logic [CW-1:0] ip1, kp1, kp2, prev_pos;
  logic          drop, tri3;

  assign ip1      = i + One;
  assign kp1      = k + One;
  assign kp2      = k + CW'(2);
  assign prev_pos = (i == '0) ? (live - One) : (i - One);

  always_comb begin
    state_next = state;
    case (state)
      pec_pkg::ST_LOAD:  if (in_valid && final_vertex) state_next = pec_pkg::ST_I0;
      pec_pkg::ST_I0:    state_next = pec_pkg::ST_I1;
      pec_pkg::ST_I1:    state_next = pec_pkg::ST_I2;
      pec_pkg::ST_I2:    state_next = pec_pkg::ST_I3;
      pec_pkg::ST_I3:    state_next = pec_pkg::ST_FILL;
      pec_pkg::ST_FILL: begin
        if (k == live) begin
          state_next = (live != '0) ? pec_pkg::ST_PASS : pec_pkg::ST_FIN;
        end
      end
      pec_pkg::ST_PASS: begin
        if (ip1 < live) begin
          state_next = pec_pkg::ST_E0;
        end else if (pass_start == live || live <= CW'(3)) begin
          state_next = pec_pkg::ST_FIN;
        end
      end
      pec_pkg::ST_E0:    state_next = pec_pkg::ST_E1;
      pec_pkg::ST_E1:    state_next = pec_pkg::ST_E2;
      pec_pkg::ST_E2:    state_next = pec_pkg::ST_E3;
      pec_pkg::ST_E3:    state_next = pec_pkg::ST_E4;
      pec_pkg::ST_E4:    state_next = pec_pkg::ST_E5;
      pec_pkg::ST_E5:    state_next = pec_pkg::ST_E6;
      pec_pkg::ST_E6:    state_next = pec_pkg::ST_E7;
      pec_pkg::ST_E7:    state_next = status.cr_nonpos ? pec_pkg::ST_K0 : pec_pkg::ST_PASS;
      pec_pkg::ST_K0:    state_next = pec_pkg::ST_K1;
      pec_pkg::ST_K1:    state_next = pec_pkg::ST_K2;
      pec_pkg::ST_K2:    state_next = pec_pkg::ST_K3;
      pec_pkg::ST_K3:    state_next = pec_pkg::ST_K4;
      pec_pkg::ST_K4:    state_next = pec_pkg::ST_K5;
      pec_pkg::ST_K5:    state_next = pec_pkg::ST_K6;
      pec_pkg::ST_K6:    state_next = pec_pkg::ST_K7;
      pec_pkg::ST_K7: begin
        if (status.blocked) begin
          state_next = pec_pkg::ST_PASS;
        end else if (kp1 < live) begin
          state_next = pec_pkg::ST_K0;
        end else begin
          state_next = pec_pkg::ST_EMIT;
        end
      end
      pec_pkg::ST_EMIT:  if (status.out_free) state_next = pec_pkg::ST_SH_RD;
      pec_pkg::ST_SH_RD: state_next = pec_pkg::ST_SH_WR;
      pec_pkg::ST_SH_WR: state_next = (kp2 < live) ? pec_pkg::ST_SH_RD : pec_pkg::ST_PASS;
      pec_pkg::ST_FIN:   state_next = (live == CW'(3)) ? pec_pkg::ST_F0 : pec_pkg::ST_END;
      pec_pkg::ST_F0:    state_next = pec_pkg::ST_F1;
      pec_pkg::ST_F1:    state_next = pec_pkg::ST_F2;
      pec_pkg::ST_F2:    state_next = pec_pkg::ST_F3;
      pec_pkg::ST_F3:    state_next = pec_pkg::ST_F4;
      pec_pkg::ST_F4:    if (status.out_free) state_next = pec_pkg::ST_END;
      pec_pkg::ST_END:   if (status.out_free) state_next = pec_pkg::ST_LOAD;
      default:           state_next = pec_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    vtx_waddr   = load_count[IW-1:0];
    coord_raddr = '0;
    list_raddr  = '0;
    list_waddr  = k[IW-1:0];
    list_wdata  = k[IW-1:0] + IW'(drop);
    out_left    = tri3 ? CW'(0) : live;
    case (state)
      pec_pkg::ST_LOAD: begin
        in_ready   = 1'b1;
        cmd.vtx_we = in_valid && (load_count < MaxCnt);
      end
      pec_pkg::ST_I0: coord_raddr = '0;
      pec_pkg::ST_I1: begin
        cmd.cap_pt     = 1'b1;
        cmd.cap_pt_sel = pec_pkg::SEL_A;
        coord_raddr    = IW'(load_count - One);
      end
      pec_pkg::ST_I2: begin
        cmd.cap_pt     = 1'b1;
        cmd.cap_pt_sel = pec_pkg::SEL_B;
      end
      pec_pkg::ST_FILL: cmd.list_we = (k != live);
      pec_pkg::ST_E0: list_raddr = prev_pos[IW-1:0];
      pec_pkg::ST_E1: begin
        cmd.cap_idx     = 1'b1;
        cmd.cap_idx_sel = pec_pkg::SEL_A;
        list_raddr      = i[IW-1:0];
      end
      pec_pkg::ST_E2: begin
        cmd.cap_idx        = 1'b1;
        cmd.cap_idx_sel    = pec_pkg::SEL_B;
        list_raddr         = ip1[IW-1:0];
        cmd.coord_from_idx = 1'b1;
        cmd.coord_idx_sel  = pec_pkg::SEL_A;
      end
      pec_pkg::ST_E3: begin
        cmd.cap_idx        = 1'b1;
        cmd.cap_idx_sel    = pec_pkg::SEL_C;
        cmd.coord_from_idx = 1'b1;
        cmd.coord_idx_sel  = pec_pkg::SEL_B;
        cmd.cap_pt         = 1'b1;
        cmd.cap_pt_sel     = pec_pkg::SEL_A;
      end
      pec_pkg::ST_E4: begin
        cmd.coord_from_idx = 1'b1;
        cmd.coord_idx_sel  = pec_pkg::SEL_C;
        cmd.cap_pt         = 1'b1;
        cmd.cap_pt_sel     = pec_pkg::SEL_B;
      end
      pec_pkg::ST_E5: begin
        cmd.cap_pt     = 1'b1;
        cmd.cap_pt_sel = pec_pkg::SEL_C;
      end
      pec_pkg::ST_E6: cmd.geom_mode = pec_pkg::G_ABC;
      pec_pkg::ST_K0: list_raddr = k[IW-1:0];
      pec_pkg::ST_K1: begin
        cmd.cap_idx     = 1'b1;
        cmd.cap_idx_sel = pec_pkg::SEL_P;
      end
      pec_pkg::ST_K2: begin
        cmd.coord_from_idx = 1'b1;
        cmd.coord_idx_sel  = pec_pkg::SEL_P;
      end
      pec_pkg::ST_K3: begin
        cmd.cap_pt     = 1'b1;
        cmd.cap_pt_sel = pec_pkg::SEL_P;
      end
      pec_pkg::ST_K4: cmd.geom_mode = pec_pkg::G_ABP;
      pec_pkg::ST_K5: begin
        cmd.geom_mode = pec_pkg::G_BCP;
        cmd.acc_load  = 1'b1;
      end
      pec_pkg::ST_K6: begin
        cmd.geom_mode = pec_pkg::G_CAP;
        cmd.acc_and   = 1'b1;
      end
      pec_pkg::ST_EMIT: cmd.out_load = status.out_free;
      pec_pkg::ST_SH_RD: list_raddr = kp1[IW-1:0];
      pec_pkg::ST_SH_WR: begin
        cmd.list_we      = 1'b1;
        cmd.list_from_rd = 1'b1;
      end
      pec_pkg::ST_F0: list_raddr = '0;
      pec_pkg::ST_F1: begin
        cmd.cap_idx     = 1'b1;
        cmd.cap_idx_sel = pec_pkg::SEL_A;
        list_raddr      = IW'(1);
      end
      pec_pkg::ST_F2: begin
        cmd.cap_idx     = 1'b1;
        cmd.cap_idx_sel = pec_pkg::SEL_B;
        list_raddr      = IW'(2);
      end
      pec_pkg::ST_F3: begin
        cmd.cap_idx     = 1'b1;
        cmd.cap_idx_sel = pec_pkg::SEL_C;
      end
      pec_pkg::ST_F4: cmd.out_load = status.out_free;
      pec_pkg::ST_END: begin
        cmd.out_load = status.out_free;
        cmd.out_end  = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pec_pkg::ST_LOAD;
      load_count <= '0;
      live       <= '0;
      pass_start <= '0;
      i          <= '0;
      k          <= '0;
      drop       <= 1'b0;
      tri3       <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        pec_pkg::ST_LOAD: begin
          if (in_valid && (load_count < MaxCnt)) begin
            load_count <= load_count + One;
          end
        end
        pec_pkg::ST_I3: begin
          drop <= status.same_ab;
          live <= load_count - CW'(status.same_ab);
          k    <= '0;
        end
        pec_pkg::ST_FILL: begin
          if (k != live) begin
            k <= kp1;
          end else begin
            pass_start <= live;
            i          <= '0;
          end
        end
        pec_pkg::ST_PASS: begin
          if (!(ip1 < live)) begin
            pass_start <= live;
            i          <= '0;
          end
        end
        pec_pkg::ST_E7: begin
          if (!status.cr_nonpos) begin
            i <= ip1;
          end
          k <= '0;
        end
        pec_pkg::ST_K7: begin
          if (status.blocked) begin
            i <= ip1;
          end else if (kp1 < live) begin
            k <= kp1;
          end
        end
        pec_pkg::ST_EMIT: k <= i;
        pec_pkg::ST_SH_WR: begin
          if (kp2 < live) begin
            k <= kp1;
          end else begin
            live <= live - One;
            i    <= ip1;
          end
        end
        pec_pkg::ST_FIN: tri3 <= (live == CW'(3));
        pec_pkg::ST_END: begin
          if (status.out_free) begin
            load_count <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `PEC_ASSERT_IMP(a_load_when_free, cmd.out_load, status.out_free, "result load while busy")
  `PEC_ASSERT_IMP(a_pass_shrinks, state == pec_pkg::ST_PASS, live <= pass_start, "list grew in pass")
  `PEC_ASSERT(a_load_bound, load_count <= MaxCnt, "load count past capacity")

endmodule

// ----- rtl/polygon_ear_clipping.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_ear_clipping
// Ear clipping triangulation of one simple polygon given as fixed point x,y.
// ----------------------------------------------------------------------------
// Input channel: one vertex per transaction, one per cycle while loading.
// final_vertex closes the polygon and starts the clipping run; vertices past
// MAX_VERTICES are dropped. in_ready is low for the whole run.
// Output channel: one triangle (input indices prev, tip, next) per ear, then
// an optional closing triangle, then an end marker with run_end set.
// Run: loading and list setup, then for each corner the corner test and, if
// it passes, each vertex checked against the candidate ear (single list and
// coordinate read port, one corner test per cycle); after each removal the
// later list entries are shifted; passes repeat while ears are found.
// A stalled receiver holds the result register and halts the sequencer at
// the next result; nothing is lost. Reset clears all control state and
// returns to loading at index 0; memories need no clearing.
// ----------------------------------------------------------------------------
module polygon_ear_clipping #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_BITS-1:0]         vertex_x,
  input  logic signed [COORD_BITS-1:0]         vertex_y,
  input  logic                                 final_vertex,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 item_kind,
  output logic [$clog2(MAX_VERTICES)-1:0]      corner_prev,
  output logic [$clog2(MAX_VERTICES)-1:0]      corner_tip,
  output logic [$clog2(MAX_VERTICES)-1:0]      corner_next,
  output logic [$clog2(MAX_VERTICES+1)-1:0]    leftover_count,
  output logic                                 run_end
);
  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  pec_pkg::cmd_t    cmd;
  pec_pkg::status_t status;
  logic [IW-1:0]    vtx_waddr, coord_raddr, list_raddr, list_waddr, list_wdata;
  logic [CW-1:0]    out_left;

  pec_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .final_vertex(final_vertex),
    .in_ready    (in_ready),
    .status      (status),
    .cmd         (cmd),
    .vtx_waddr   (vtx_waddr),
    .coord_raddr (coord_raddr),
    .list_raddr  (list_raddr),
    .list_waddr  (list_waddr),
    .list_wdata  (list_wdata),
    .out_left    (out_left)
  );

  pec_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .vtx_waddr     (vtx_waddr),
    .coord_raddr   (coord_raddr),
    .list_raddr    (list_raddr),
    .list_waddr    (list_waddr),
    .list_wdata    (list_wdata),
    .out_left      (out_left),
    .vertex_x      (vertex_x),
    .vertex_y      (vertex_y),
    .out_ready     (out_ready),
    .status        (status),
    .out_valid     (out_valid),
    .item_kind     (item_kind),
    .corner_prev   (corner_prev),
    .corner_tip    (corner_tip),
    .corner_next   (corner_next),
    .leftover_count(leftover_count),
    .run_end       (run_end)
  );

endmodule
